>>> sv/clrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clrs_pkg;

  // Default ring capacity
  localparam int unsigned DEPTH = 16;

  // Fixed field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned POS_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_SEARCH    = 3'd2,
    CMD_ROT_LEFT  = 3'd3,
    CMD_ROT_RIGHT = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

`default_nettype wire

>>> sv/clrs_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clrs_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [clrs_pkg::CMD_W-1:0]          command;
  logic signed [clrs_pkg::KEY_W-1:0]   key;

  modport source (output valid, command, key, input ready);
  modport sink   (input valid, command, key, output ready);
endinterface

`default_nettype wire

>>> sv/clrs_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clrs_res_if;
  logic                        valid;
  logic                        ready;
  logic [clrs_pkg::STAT_W-1:0] status;
  logic [clrs_pkg::CNT_W-1:0]  match_count;
  logic [clrs_pkg::POS_W-1:0]  first_match_position;
  logic [clrs_pkg::CNT_W-1:0]  occupancy;

  modport source (output valid, status, match_count, first_match_position, occupancy,
                  input ready);
  modport sink   (input valid, status, match_count, first_match_position, occupancy,
                  output ready);
endinterface

`default_nettype wire

>>> sv/circular_list_rotate_search_core.sv
// Insert, remove, rejected, unknown commands and empty searches answer on acceptance;
//   rotates pass S_ROT_L/S_ROT_R; a search does one ring read per entry in S_SEARCH.
// Throughput: one command at a time; the next beat is taken once the controller is
//   back in idle and the result register is free or draining.
// Reset (async, active low): ring empty, front at entry 0, no result pending.
//   Ring contents are not cleared; only occupied entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module circular_list_rotate_search_core #(
  parameter int unsigned DEPTH = clrs_pkg::DEPTH
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  clrs_cmd_if.sink      cmd_i,
  clrs_res_if.source    res_o
);

  // Widths derived from the ring capacity
  localparam int unsigned IW   = (DEPTH > 2) ? $clog2(DEPTH) : 1; // ring index
  localparam int unsigned CW   = $clog2(DEPTH + 1);               // entry count
  localparam int unsigned SW   = CW + 1;                          // index + count sum
  localparam int unsigned KeyW = clrs_pkg::KEY_W;
  localparam int unsigned CntW = clrs_pkg::CNT_W;
  localparam int unsigned PosW = clrs_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_ROT_L,
    S_ROT_R
  } state_e;

  // Reduce a sum below 2*DEPTH into a ring index
  function automatic logic [IW-1:0] ring_wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return r[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] idx);
    return (idx == IW'(DEPTH - 1)) ? '0 : (idx + IW'(1));
  endfunction

  function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] idx);
    return (idx == '0) ? IW'(DEPTH - 1) : (idx - IW'(1));
  endfunction

  // ---------------------------------------------------------------------------
  // Ring store: one write port, one read port, registered read data.
  // Commands run one at a time, and a rotate writes back only in the cycle after
  // its read, so no read and write to the same entry ever overlap.
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0] mem_q [DEPTH];
  logic [KeyW-1:0] mem_rdata_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [KeyW-1:0] mem_wdata;
  logic [IW-1:0]   mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [IW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [IW-1:0]     addr_q, addr_d;     // ring address of the entry being compared
  logic [IW-1:0]     pos_q, pos_d;       // its position from the front
  logic [CW-1:0]     match_q, match_d;
  logic [IW-1:0]     first_q, first_d;

  // Result register
  logic                  out_valid_q, out_valid_d;
  clrs_pkg::status_e     out_status_q, out_status_d;
  logic [CW-1:0]         out_match_q, out_match_d;
  logic [IW-1:0]         out_first_q, out_first_d;
  logic [CW-1:0]         out_occ_q, out_occ_d;

  logic          in_acc;
  logic          is_full;
  logic          is_empty;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] back_idx;   // index of the back entry
  logic [IW-1:0] tail_idx;   // one past the back entry
  logic          hit;
  logic [CW-1:0] match_nxt;
  logic [IW-1:0] first_nxt;
  logic          last_pos;

  // Take a beat only in idle with room in the result register
  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || res_o.ready);
  assign in_acc      = cmd_i.valid && cmd_i.ready;

  assign is_full   = (count_q == CW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign front_dec = ring_dec(front_q);
  assign tail_idx  = ring_wrap(SW'(front_q) + SW'(count_q));
  assign back_idx  = ring_wrap(SW'(front_q) + SW'(count_q) - SW'(1));

  // Search compare on the entry whose read data just came back
  assign hit       = (mem_rdata_q == key_q);
  assign match_nxt = hit ? (match_q + CW'(1)) : match_q;
  assign first_nxt = (hit && (match_q == '0)) ? pos_q : first_q;
  assign last_pos  = ((CW'(pos_q) + CW'(1)) == count_q);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    key_d        = key_q;
    addr_d       = addr_q;
    pos_d        = pos_q;
    match_d      = match_q;
    first_d      = first_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_match_d  = out_match_q;
    out_first_d  = out_first_q;
    out_occ_d    = out_occ_q;
    mem_we       = 1'b0;
    mem_waddr    = front_q;
    mem_wdata    = key_q;
    mem_raddr    = front_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d        = cmd_i.key;
          addr_d       = front_q;
          pos_d        = '0;
          match_d      = '0;
          first_d      = '0;
          out_status_d = clrs_pkg::ST_DONE;
          out_match_d  = '0;
          out_first_d  = '0;
          out_occ_d    = count_q;
          case (clrs_pkg::cmd_e'(cmd_i.command))
            clrs_pkg::CMD_INSERT: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                out_status_d = clrs_pkg::ST_FULL;
              end else begin
                front_d   = front_dec;
                count_d   = count_q + CW'(1);
                out_occ_d = count_q + CW'(1);
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                mem_wdata = cmd_i.key;
              end
            end
            clrs_pkg::CMD_REMOVE: begin
              out_valid_d = 1'b1;
              if (is_empty) begin
                out_status_d = clrs_pkg::ST_EMPTY;
              end else begin
                front_d   = ring_inc(front_q);
                count_d   = count_q - CW'(1);
                out_occ_d = count_q - CW'(1);
              end
            end
            clrs_pkg::CMD_SEARCH: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
              end else begin
                // read of the front entry issued now
                state_d = S_SEARCH;
              end
            end
            clrs_pkg::CMD_ROT_LEFT: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_status_d = clrs_pkg::ST_EMPTY;
              end else begin
                state_d = S_ROT_L;
              end
            end
            clrs_pkg::CMD_ROT_RIGHT: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_status_d = clrs_pkg::ST_EMPTY;
              end else begin
                mem_raddr = back_idx;
                state_d   = S_ROT_R;
              end
            end
            default: begin
              // unused codes: plain done, state untouched
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_SEARCH: begin
        match_d = match_nxt;
        first_d = first_nxt;
        if (last_pos) begin
          out_valid_d  = 1'b1;
          out_status_d = clrs_pkg::ST_DONE;
          out_match_d  = match_nxt;
          out_first_d  = first_nxt;
          out_occ_d    = count_q;
          state_d      = S_IDLE;
        end else begin
          pos_d     = pos_q + IW'(1);
          addr_d    = ring_inc(addr_q);
          mem_raddr = ring_inc(addr_q);
        end
      end

      S_ROT_L: begin
        // front entry copied one past the back; a full ring writes it onto itself
        mem_we       = 1'b1;
        mem_waddr    = tail_idx;
        mem_wdata    = mem_rdata_q;
        front_d      = ring_inc(front_q);
        out_valid_d  = 1'b1;
        out_status_d = clrs_pkg::ST_DONE;
        out_occ_d    = count_q;
        state_d      = S_IDLE;
      end

      S_ROT_R: begin
        // back entry copied in front of the old front
        mem_we       = 1'b1;
        mem_waddr    = front_dec;
        mem_wdata    = mem_rdata_q;
        front_d      = front_dec;
        out_valid_d  = 1'b1;
        out_status_d = clrs_pkg::ST_DONE;
        out_occ_d    = count_q;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      front_q      <= '0;
      count_q      <= '0;
      key_q        <= '0;
      addr_q       <= '0;
      pos_q        <= '0;
      match_q      <= '0;
      first_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= clrs_pkg::ST_DONE;
      out_match_q  <= '0;
      out_first_q  <= '0;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      count_q      <= count_d;
      key_q        <= key_d;
      addr_q       <= addr_d;
      pos_q        <= pos_d;
      match_q      <= match_d;
      first_q      <= first_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_match_q  <= out_match_d;
      out_first_q  <= out_first_d;
      out_occ_q    <= out_occ_d;
    end
  end

  // Result beat, fields cut or padded to their port widths
  assign res_o.valid                = out_valid_q;
  assign res_o.status               = out_status_q;
  assign res_o.match_count          = CntW'(out_match_q);
  assign res_o.first_match_position = PosW'(out_first_q);
  assign res_o.occupancy            = CntW'(out_occ_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(DEPTH)) && (front_q <= IW'(DEPTH - 1)))
    else $error("ring count or front index out of range");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i.command == clrs_pkg::CMD_INSERT) && !is_full)
      |=> (count_q == $past(count_q) + CW'(1)) && out_valid_q)
    else $error("accepted insert did not grow the ring");

  a_search_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> ((CW'(pos_q) < count_q) && !out_valid_q))
    else $error("search walked past the back entry");

  a_rot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ROT_L) || (state_q == S_ROT_R)) |=> $stable(count_q))
    else $error("rotate changed the entry count");

endmodule

`default_nettype wire

>>> tb/tb_circular_list_rotate_search_core.sv
`timescale 1ns / 1ps

module tb_circular_list_rotate_search_core;

  // Field widths taken from the package
  localparam int unsigned CmdW = clrs_pkg::CMD_W;
  localparam int unsigned KeyW = clrs_pkg::KEY_W;
  localparam int unsigned CntW = clrs_pkg::CNT_W;
  localparam int unsigned PosW = clrs_pkg::POS_W;

  // Run control
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned DRAIN_CYCLES = clrs_pkg::DEPTH + 8;  // longest search plus margin
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned REPORT_MAX   = 10;

  // Codes past the defined command set; the block ignores them
  localparam logic [CmdW-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_UNUSED_LAST  = 3'd7;

  // One result beat as the predictor sees it
  typedef struct packed {
    clrs_pkg::status_e status;
    logic [CntW-1:0]   match_count;
    logic [PosW-1:0]   first_pos;
    logic [CntW-1:0]   occupancy;
  } list_result_t;

  // Command mix for one phase of random traffic
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_e;

  logic clk_i;
  logic rst_ni;

  clrs_cmd_if cmd_if ();
  clrs_res_if res_if ();

  circular_list_rotate_search_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // Predictor copy of the ring: keys, front slot and number held
  logic [KeyW-1:0] list_keys [clrs_pkg::DEPTH];
  int unsigned     head_idx = 0;
  int unsigned     n_keys   = 0;

  // Results owed by the block, oldest first
  list_result_t pending_results [$];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // Idle control shared between the stimulus and the receiver
  int unsigned hold_left   = 0;  // long receiver hold-off, counted down by the receiver
  int unsigned stall_left  = 0;
  bit          tx_no_gap   = 1'b0;
  bit          rx_no_stall = 1'b0;

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one command to the predictor ring and return the result it owes.
  // Rejected and unused commands leave the ring as it was.
  function automatic list_result_t apply_command(input logic [CmdW-1:0] op,
                                                 input logic [KeyW-1:0] k);
    list_result_t    res;
    logic [KeyW-1:0] moved;
    res.status      = clrs_pkg::ST_DONE;
    res.match_count = '0;
    res.first_pos   = '0;
    case (op)
      clrs_pkg::CMD_INSERT: begin
        if (n_keys >= clrs_pkg::DEPTH) begin
          res.status = clrs_pkg::ST_FULL;
        end else begin
          head_idx = (head_idx + clrs_pkg::DEPTH - 1) % clrs_pkg::DEPTH;
          list_keys[head_idx] = k;
          n_keys++;
        end
      end
      clrs_pkg::CMD_REMOVE: begin
        if (n_keys == 0) begin
          res.status = clrs_pkg::ST_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % clrs_pkg::DEPTH;
          n_keys--;
        end
      end
      clrs_pkg::CMD_SEARCH: begin
        for (int unsigned i = 0; i < n_keys; i++) begin
          if (list_keys[(head_idx + i) % clrs_pkg::DEPTH] == k) begin
            if (res.match_count == 0) res.first_pos = PosW'(i);
            res.match_count++;
          end
        end
      end
      clrs_pkg::CMD_ROT_LEFT: begin
        // front key is copied behind the back, then the front moves on;
        // on a full ring the copy lands on the front slot itself
        if (n_keys == 0) begin
          res.status = clrs_pkg::ST_EMPTY;
        end else begin
          list_keys[(head_idx + n_keys) % clrs_pkg::DEPTH] = list_keys[head_idx];
          head_idx = (head_idx + 1) % clrs_pkg::DEPTH;
        end
      end
      clrs_pkg::CMD_ROT_RIGHT: begin
        if (n_keys == 0) begin
          res.status = clrs_pkg::ST_EMPTY;
        end else begin
          moved    = list_keys[(head_idx + n_keys - 1) % clrs_pkg::DEPTH];
          head_idx = (head_idx + clrs_pkg::DEPTH - 1) % clrs_pkg::DEPTH;
          list_keys[head_idx] = moved;
        end
      end
      default: ;
    endcase
    res.occupancy = CntW'(n_keys);
    return res;
  endfunction

  // Extremes and a small pool of values so that duplicates come up often
  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4, 5:    return KeyW'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // Searches mostly look for a key that is held right now
  function automatic logic [KeyW-1:0] pick_search_key();
    if (n_keys > 0 && $urandom_range(0, 9) < 7)
      return list_keys[(head_idx + $urandom_range(0, n_keys - 1)) % clrs_pkg::DEPTH];
    return pick_key();
  endfunction

  function automatic logic [CmdW-1:0] pick_command(input traffic_mix_e mix);
    int unsigned ins_w;
    int unsigned rem_w;
    int unsigned r;
    ins_w = (mix == MIX_GROW) ? 50 : (mix == MIX_SHRINK) ? 10 : 28;
    rem_w = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 50 : 22;
    r = $urandom_range(0, 99);
    if (r < ins_w) return clrs_pkg::CMD_INSERT;
    if (r < ins_w + rem_w) return clrs_pkg::CMD_REMOVE;
    if (r < ins_w + rem_w + 20) return clrs_pkg::CMD_SEARCH;
    if (r < 96) return r[0] ? clrs_pkg::CMD_ROT_LEFT : clrs_pkg::CMD_ROT_RIGHT;
    return CmdW'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
  endfunction

  // Offer one command beat, wait for it to be taken, book its result, then
  // maybe idle. Valid stays high on return when no gap follows, so the next
  // call drives the new beat in the same step without a low pulse.
  task automatic send_cmd(input logic [CmdW-1:0] op, input logic [KeyW-1:0] k);
    int unsigned gap;
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= op;
    cmd_if.key     <= k;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    pending_results.push_back(apply_command(op, k));
    gap = tx_no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending until every owed result is back, then let the block settle
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Rejections on an empty ring, empty search, and the ignored codes
  task automatic test_empty_list();
    send_cmd(clrs_pkg::CMD_REMOVE, $urandom());
    send_cmd(clrs_pkg::CMD_ROT_LEFT, $urandom());
    send_cmd(clrs_pkg::CMD_ROT_RIGHT, $urandom());
    send_cmd(clrs_pkg::CMD_SEARCH, 32'h0);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      send_cmd(CmdW'(c), $urandom());
  endtask

  // Extreme keys, rotation of a single entry, search positions, and removal
  // down through two entries and one entry to empty
  task automatic test_short_list();
    send_cmd(clrs_pkg::CMD_INSERT, 32'h7fff_ffff);
    send_cmd(clrs_pkg::CMD_ROT_LEFT, '0);
    send_cmd(clrs_pkg::CMD_ROT_RIGHT, '0);
    send_cmd(clrs_pkg::CMD_SEARCH, 32'h7fff_ffff);
    send_cmd(clrs_pkg::CMD_INSERT, 32'h8000_0000);
    send_cmd(clrs_pkg::CMD_INSERT, 32'h0000_0000);
    send_cmd(clrs_pkg::CMD_INSERT, 32'hffff_ffff);
    send_cmd(clrs_pkg::CMD_SEARCH, 32'h8000_0000);   // third from the front
    send_cmd(clrs_pkg::CMD_ROT_RIGHT, '0);           // back key comes to the front
    send_cmd(clrs_pkg::CMD_SEARCH, 32'h7fff_ffff);
    send_cmd(clrs_pkg::CMD_ROT_LEFT, '0);
    send_cmd(clrs_pkg::CMD_REMOVE, '0);
    send_cmd(clrs_pkg::CMD_REMOVE, '0);
    send_cmd(clrs_pkg::CMD_REMOVE, '0);              // two entries leave one
    send_cmd(clrs_pkg::CMD_REMOVE, '0);              // last entry goes
    send_cmd(clrs_pkg::CMD_SEARCH, 32'hffff_ffff);
  endtask

  // Fill the ring while the receiver holds off, so the block backs up and
  // stalls its command side. Covers insert on full, a lone match at the back,
  // rotation of a full ring and a search that hits every entry.
  task automatic test_full_ring_backpressure();
    logic [KeyW-1:0] lone_key;
    logic [KeyW-1:0] bulk_key;
    logic [KeyW-1:0] fill_key;
    lone_key = $urandom();
    bulk_key = ~lone_key;
    fill_key = $urandom();
    while (n_keys != 0) send_cmd(clrs_pkg::CMD_REMOVE, $urandom());
    drain_results();

    tx_no_gap = 1'b1;
    hold_left = 400;
    send_cmd(clrs_pkg::CMD_INSERT, lone_key);
    repeat (clrs_pkg::DEPTH - 1) send_cmd(clrs_pkg::CMD_INSERT, bulk_key);
    send_cmd(clrs_pkg::CMD_INSERT, fill_key);        // ring full: rejected
    send_cmd(clrs_pkg::CMD_SEARCH, lone_key);        // single match at the back
    send_cmd(clrs_pkg::CMD_SEARCH, bulk_key);
    send_cmd(clrs_pkg::CMD_ROT_LEFT, fill_key);
    send_cmd(clrs_pkg::CMD_SEARCH, lone_key);
    send_cmd(clrs_pkg::CMD_ROT_RIGHT, fill_key);
    send_cmd(clrs_pkg::CMD_ROT_RIGHT, fill_key);
    send_cmd(clrs_pkg::CMD_SEARCH, lone_key);
    tx_no_gap = 1'b0;
    drain_results();

    // empty it again, one remove past empty
    repeat (clrs_pkg::DEPTH + 1) send_cmd(clrs_pkg::CMD_REMOVE, $urandom());

    // every entry the same key: full match count
    tx_no_gap = 1'b1;
    hold_left = 200;
    repeat (clrs_pkg::DEPTH) send_cmd(clrs_pkg::CMD_INSERT, fill_key);
    send_cmd(clrs_pkg::CMD_SEARCH, fill_key);
    tx_no_gap = 1'b0;
    repeat (clrs_pkg::DEPTH) send_cmd(clrs_pkg::CMD_REMOVE, $urandom());
    drain_results();
  endtask

  // Phases that grow, shrink or churn the ring so that it swings between
  // empty and full; each phase may also switch off idling on either side.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned     done_items;
    int unsigned     phase_left;
    traffic_mix_e    mix;
    logic [CmdW-1:0] op;
    logic [KeyW-1:0] k;
    done_items = 0;
    phase_left = 0;
    mix        = MIX_BALANCED;
    while (done_items < n_items) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0:       mix = MIX_GROW;
          1:       mix = MIX_SHRINK;
          default: mix = MIX_BALANCED;
        endcase
        tx_no_gap   = ($urandom_range(0, 4) == 0);
        rx_no_stall = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(50, 200);
      end
      op = pick_command(mix);
      k  = (op == clrs_pkg::CMD_SEARCH) ? pick_search_key() : pick_key();
      send_cmd(op, k);
      // ignored codes do not count as traffic
      if (op <= clrs_pkg::CMD_ROT_RIGHT) done_items++;
      phase_left--;
    end
    tx_no_gap   = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  // Result side ready: long hold-off first, then random stalls unless switched off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else if (rx_no_stall) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = pick_gap() + 1;
    end
  end

  // Check each result beat against the oldest owed result
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("%0t: result beat with none owed: status %0d count %0d pos %0d occ %0d",
                   $time, res_if.status, res_if.match_count, res_if.first_match_position,
                   res_if.occupancy);
      end else begin
        want = pending_results.pop_front();
        if (res_if.status !== want.status || res_if.match_count !== want.match_count ||
            res_if.first_match_position !== want.first_pos ||
            res_if.occupancy !== want.occupancy) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: mismatch: exp status %0d count %0d pos %0d occ %0d, got %0d %0d %0d %0d",
                     $time, want.status, want.match_count, want.first_pos, want.occupancy,
                     res_if.status, res_if.match_count, res_if.first_match_position,
                     res_if.occupancy);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cmd_if.valid   = 1'b0;
    cmd_if.command = clrs_pkg::CMD_INSERT;
    cmd_if.key     = '0;
    res_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_short_list();
    test_full_ring_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    drain_results();

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
